// File: rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    // fixed field widths
    localparam int MSG_W = 32;
    localparam int KEY_W = 31;
    localparam int CNT_W = 5;

    // configuration register indexes
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // modular multiply operations
    localparam logic [1:0] OP_REDUCE = 2'd0;
    localparam logic [1:0] OP_SQUARE = 2'd1;
    localparam logic [1:0] OP_MULT   = 2'd2;

    // output word selection
    localparam logic [1:0] OUT_ACC = 2'd0;
    localparam logic [1:0] OUT_ONE = 2'd1;
    localparam logic [1:0] OUT_ERR = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic       load_out;
        logic [1:0] out_sel;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/mexp_datapath.sv
`default_nettype none

module mexp_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mexp_pkg::t_cmd              i_cmd,
    input  wire logic [mexp_pkg::MSG_W-1:0]  i_message,
    input  wire logic [mexp_pkg::KEY_W-1:0]  i_modulus,
    output mexp_pkg::t_status                o_status,
    output logic      [mexp_pkg::KEY_W-1:0]  o_result,
    output logic                             o_error
);

    localparam int MW = mexp_pkg::MSG_W;
    localparam int KW = mexp_pkg::KEY_W;
    localparam int CW = mexp_pkg::CNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [1:0]    r_dest, n_dest;
    logic [KW-1:0] r_mr,   n_mr;
    logic [MW-1:0] r_ma,   n_ma;
    logic [KW-1:0] r_mb,   n_mb;
    logic [KW-1:0] r_acc,  n_acc;
    logic [KW-1:0] r_base, n_base;
    logic [KW-1:0] r_result, n_result;
    logic          r_error,  n_error;

    logic [MW-1:0] w_mod;
    logic [MW-1:0] w_dbl;
    logic [MW-1:0] w_red1;
    logic [MW-1:0] w_add;
    logic [MW-1:0] w_red2;
    logic [KW-1:0] w_next;

    // one multiplier bit per cycle: double, reduce, add, reduce
    always_comb begin
        w_mod  = {1'b0, i_modulus};
        w_dbl  = {r_mr, 1'b0};
        w_red1 = (w_dbl >= w_mod) ? (w_dbl - w_mod) : w_dbl;
        w_add  = w_red1 + (r_ma[MW-1] ? {1'b0, r_mb} : '0);
        w_red2 = (w_add >= w_mod) ? (w_add - w_mod) : w_add;
        w_next = w_red2[KW-1:0];
    end

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_dest   = r_dest;
        n_mr     = r_mr;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_acc    = r_acc;
        n_base   = r_base;
        n_result = r_result;
        n_error  = r_error;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt  = '1;
            n_dest = i_cmd.op;
            n_mr   = '0;
            case (i_cmd.op)
                mexp_pkg::OP_REDUCE: begin
                    n_ma  = i_message;
                    n_mb  = KW'(1);
                    n_acc = KW'(1);
                end
                mexp_pkg::OP_SQUARE: begin
                    n_ma = {1'b0, r_acc};
                    n_mb = r_acc;
                end
                mexp_pkg::OP_MULT: begin
                    n_ma = {1'b0, r_acc};
                    n_mb = r_base;
                end
                default: begin
                    n_ma = '0;
                    n_mb = '0;
                end
            endcase
        end else if (r_busy) begin
            n_mr  = w_next;
            n_ma  = {r_ma[MW-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_dest == mexp_pkg::OP_REDUCE) begin
                    n_base = w_next;
                end else begin
                    n_acc = w_next;
                end
            end
        end
        if (i_cmd.load_out) begin
            case (i_cmd.out_sel)
                mexp_pkg::OUT_ACC: begin
                    n_result = r_acc;
                    n_error  = 1'b0;
                end
                mexp_pkg::OUT_ONE: begin
                    n_result = KW'(1);
                    n_error  = 1'b0;
                end
                mexp_pkg::OUT_ERR: begin
                    n_result = '0;
                    n_error  = 1'b1;
                end
                default: begin
                    n_result = '0;
                    n_error  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_dest   <= n_dest;
        r_mr     <= n_mr;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_result <= n_result;
        r_error  <= n_error;
    end

    assign o_status = mexp_pkg::t_status'{busy: r_busy, done: r_done};
    assign o_result = r_result;
    assign o_error  = r_error;

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_busy && r_cnt == '1))
        else $error("multiply start did not arm the bit counter");

    a_residue_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (i_modulus == '0 || r_mr < i_modulus))
        else $error("partial residue not reduced below modulus");

endmodule

`default_nettype wire

// File: rtl/mexp_ctrl.sv
`default_nettype none

module mexp_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    input  wire logic [mexp_pkg::KEY_W-1:0]  i_exponent,
    input  wire logic                        i_mod_zero,
    input  wire mexp_pkg::t_status           i_status,
    output mexp_pkg::t_cmd                   o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int CW = mexp_pkg::CNT_W;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_bit,   n_bit;
    logic [1:0]    r_sel,   n_sel;
    logic          r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_mod_zero) begin
                        n_sel   = mexp_pkg::OUT_ERR;
                        n_state = ST_DONE;
                    end else if (i_exponent == '0) begin
                        n_sel   = mexp_pkg::OUT_ONE;
                        n_state = ST_DONE;
                    end else begin
                        n_sel       = mexp_pkg::OUT_ACC;
                        o_cmd.start = 1'b1;
                        o_cmd.op    = mexp_pkg::OP_REDUCE;
                        n_state     = ST_RED;
                    end
                end
            end
            ST_RED: begin
                if (i_status.done) begin
                    n_bit       = CW'(mexp_pkg::KEY_W - 1);
                    o_cmd.start = 1'b1;
                    o_cmd.op    = mexp_pkg::OP_SQUARE;
                    n_state     = ST_SQ;
                end
            end
            ST_SQ: begin
                if (i_status.done) begin
                    if (i_exponent[r_bit]) begin
                        o_cmd.start = 1'b1;
                        o_cmd.op    = mexp_pkg::OP_MULT;
                        n_state     = ST_MUL;
                    end else if (r_bit == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_bit       = r_bit - CW'(1);
                        o_cmd.start = 1'b1;
                        o_cmd.op    = mexp_pkg::OP_SQUARE;
                    end
                end
            end
            ST_MUL: begin
                if (i_status.done) begin
                    if (r_bit == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_bit       = r_bit - CW'(1);
                        o_cmd.start = 1'b1;
                        o_cmd.op    = mexp_pkg::OP_SQUARE;
                        n_state     = ST_SQ;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = r_sel;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
        r_sel <= n_sel;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !i_status.busy)
        else $error("multiply started while unit busy");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.done |-> (r_state == ST_RED || r_state == ST_SQ || r_state == ST_MUL))
        else $error("multiply finished with no step waiting");

    a_reduce_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid && !i_mod_zero && i_exponent != '0)
        |=> i_status.busy)
        else $error("accepted word did not start reduction");

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation.sv
`default_nettype none

// rsa modular exponentiation: each accepted message word gives one result word,
// (message mod modulus) ^ exponent mod modulus, with the key (exponent, modulus)
// held in two config registers (index 0 exponent, index 1 modulus, both reset to 1).
// only the low WORD_BITS bits of the message are used. a zero modulus gives
// result 0 with error set, and a zero exponent gives 1; both finish without
// touching the arithmetic. otherwise the message is first reduced mod n, then
// square-and-multiply runs over all 31 exponent bits, msb first. every modular
// multiply goes through one shared shift-and-add unit that handles one
// multiplier bit per cycle. one word is in work at a time; the result sits in
// an output register, so the next word is taken as soon as the result is
// loaded there.

module modular_exponentiation #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [mexp_pkg::MSG_W-1:0]  i_message,
    // output channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [mexp_pkg::KEY_W-1:0]  o_result,
    output logic                             o_error,
    // config write port
    input  wire logic                        i_wr_en,
    input  wire logic                        i_wr_index,
    input  wire logic [mexp_pkg::KEY_W-1:0]  i_wr_data
);

    localparam int MW = mexp_pkg::MSG_W;
    localparam int KW = mexp_pkg::KEY_W;

    logic [KW-1:0] r_exponent, n_exponent;
    logic [KW-1:0] r_modulus,  n_modulus;
    logic [MW-1:0] w_message;

    mexp_pkg::t_cmd    w_cmd;
    mexp_pkg::t_status w_status;

    // key registers; the user must write them only while the block is idle, the block itself does not enforce it
    always_comb begin
        n_exponent = r_exponent;
        n_modulus  = r_modulus;
        if (i_wr_en) begin
            case (i_wr_index)
                mexp_pkg::REG_EXPONENT: n_exponent = i_wr_data;
                mexp_pkg::REG_MODULUS:  n_modulus  = i_wr_data;
                default: begin
                    n_exponent = r_exponent;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= KW'(1);
            r_modulus  <= KW'(1);
        end else begin
            r_exponent <= n_exponent;
            r_modulus  <= n_modulus;
        end
    end

    // keep only the low WORD_BITS bits of the message word
    always_comb begin
        for (int i = 0; i < MW; i++) begin
            w_message[i] = (i < WORD_BITS) ? i_message[i] : 1'b0;
        end
    end

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_exponent (r_exponent),
        .i_mod_zero (r_modulus == '0),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mexp_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_message (w_message),
        .i_modulus (r_modulus),
        .o_status  (w_status),
        .o_result  (o_result),
        .o_error   (o_error)
    );

endmodule

`default_nettype wire
